// ===== rtl/tssb_pkg.sv =====
// ----------------------------------------------------------------------------
// tssb_pkg
// Shared types and constants of the time sorted sample buffer.
// ----------------------------------------------------------------------------
package tssb_pkg;

    localparam int STAMP_W   = 62;
    localparam int AGE_W     = 40;
    localparam int PAYLOAD_W = 32;
    localparam int APB_W     = 64;
    localparam int ADDR_W    = 4;

    localparam int DEPTH_DEF     = 64;
    localparam int DATA_BITS_DEF = 32;

    localparam logic [AGE_W-1:0] AGE_RESET = 40'd10000000000;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_EMPTY    = 3'd1;
    localparam logic [2:0] ERR_MISMATCH = 3'd2;
    localparam logic [2:0] ERR_FUTURE   = 3'd3;
    localparam logic [2:0] ERR_PAST     = 3'd4;

    localparam logic REG_MAX_AGE = 1'b0;

    typedef struct packed {
        logic                 cmd;
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic                 inserted;
        logic [1:0]           match_count;
        logic [2:0]           error_kind;
        logic [STAMP_W-1:0]   first_stamp;
        logic [PAYLOAD_W-1:0] first_data;
        logic [STAMP_W-1:0]   second_stamp;
        logic [PAYLOAD_W-1:0] second_data;
        logic [STAMP_W-1:0]   bound_stamp;
    } t_result;

    typedef struct packed {
        logic occ;
        logic gt;
        logic le;
        logic hit;
        logic keep;
    } t_cell_stat;

endpackage

// ===== rtl/time_sorted_sample_buffer.sv =====
// ----------------------------------------------------------------------------
// time_sorted_sample_buffer
// Stamped entries kept newest first in a row of cells, with insert, age
// pruning and bracketing lookup.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A lookup or a refused
// insert finishes in the cycle it is taken; an accepted insert shifts the row
// in that cycle and then holds busy high for the prune pass before it
// finishes. Both come from one broadcast compare of the request stamp against
// every cell of the row. The result appears on o_result for exactly one cycle
// with o_valid high, in the cycle after the request finishes, and must be
// taken then: there is no way to hold it off.
// ----------------------------------------------------------------------------
module time_sorted_sample_buffer
    import tssb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_valid,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (DATA_BITS > PAYLOAD_W) ? DATA_BITS : PAYLOAD_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    function automatic logic [PAYLOAD_W-1:0] to_word(input logic [DATA_BITS-1:0] d);
        logic [XW-1:0] e;
        e = XW'(d);
        return e[PAYLOAD_W-1:0];
    endfunction

    logic [AGE_W-1:0]     r_max_age;
    logic [CW-1:0]        r_count;
    logic                 r_busy;
    logic                 r_valid;
    t_result              r_result;

    logic [STAMP_W-1:0]   cell_stamp [DEPTH];
    logic [DATA_BITS-1:0] cell_data  [DEPTH];
    t_cell_stat           cell_stat  [DEPTH];
    logic [STAMP_W-1:0]   c_first_s  [DEPTH];
    logic [DATA_BITS-1:0] c_first_d  [DEPTH];
    logic [STAMP_W-1:0]   c_second_s [DEPTH];
    logic [DATA_BITS-1:0] c_second_d [DEPTH];
    logic [STAMP_W-1:0]   c_last_s   [DEPTH];
    logic [DATA_BITS-1:0] c_last_d   [DEPTH];
    logic [DEPTH-1:0]     bnd;

    logic                 accept;
    logic                 refused;
    logic                 load;
    logic [XW-1:0]        pay_ext;
    logic [DATA_BITS-1:0] ins_data;
    logic [CW-1:0]        grown;
    logic [CW-1:0]        prune_cnt;
    logic [STAMP_W-1:0]   first_s;
    logic [DATA_BITS-1:0] first_d;
    logic [STAMP_W-1:0]   second_s;
    logic [DATA_BITS-1:0] second_d;
    logic [STAMP_W-1:0]   last_s;
    logic [DATA_BITS-1:0] last_d;
    logic [STAMP_W-1:0]   target;
    logic [STAMP_W-1:0]   latest;
    t_result              n_res;
    t_result              ins_res;
    logic                 cfg_wr;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[3] == REG_MAX_AGE);
    assign prdata = (paddr[3] == REG_MAX_AGE) ? APB_W'(r_max_age) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= AGE_RESET;
        end else if (cfg_wr) begin
            r_max_age <= pwdata[AGE_W-1:0];
        end
    end

    // request decode
    assign target   = i_req.stamp;
    assign latest   = cell_stamp[0];
    assign accept   = start & ~r_busy;
    assign pay_ext  = XW'(i_req.payload);
    assign ins_data = pay_ext[DATA_BITS-1:0];
    assign refused  = (r_count != '0) && ({1'b0, latest} >
                      ({1'b0, target} + {{(STAMP_W + 1 - AGE_W){1'b0}}, r_max_age}));
    assign load     = accept & (i_req.cmd == CMD_INSERT) & ~refused;
    assign grown    = (r_count == FULL) ? r_count : r_count + 1'b1;

    // cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        t_cell_stat           left_stat;
        t_cell_stat           right_stat;
        logic [STAMP_W-1:0]   left_s;
        logic [DATA_BITS-1:0] left_d;

        if (i == 0) begin : g_head
            assign left_stat = '{occ: 1'b1, gt: 1'b1, le: 1'b0, hit: 1'b0, keep: 1'b1};
            assign left_s    = target;
            assign left_d    = ins_data;
        end else begin : g_body
            assign left_stat = cell_stat[i-1];
            assign left_s    = cell_stamp[i-1];
            assign left_d    = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_stat = '0;
            assign bnd[i]     = cell_stat[i].keep;
        end else begin : g_inner
            assign right_stat = cell_stat[i+1];
            assign bnd[i]     = cell_stat[i].keep & ~cell_stat[i+1].keep;
        end

        tssb_cell #(
            .DATA_BITS(DATA_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_load         (load),
            .i_occ          (IDX < r_count),
            .i_key          (target),
            .i_ins_data     (ins_data),
            .i_left_stamp   (left_s),
            .i_left_data    (left_d),
            .i_left         (left_stat),
            .i_right        (right_stat),
            .i_max_age      (r_max_age),
            .i_latest       (latest),
            .o_stamp        (cell_stamp[i]),
            .o_data         (cell_data[i]),
            .o_stat         (cell_stat[i]),
            .o_first_stamp  (c_first_s[i]),
            .o_first_data   (c_first_d[i]),
            .o_second_stamp (c_second_s[i]),
            .o_second_data  (c_second_d[i]),
            .o_last_stamp   (c_last_s[i]),
            .o_last_data    (c_last_d[i])
        );
    end

    // gather one-hot selections from the row
    always_comb begin
        first_s   = '0;
        first_d   = '0;
        second_s  = '0;
        second_d  = '0;
        last_s    = '0;
        last_d    = '0;
        prune_cnt = '0;
        for (int i = 0; i < DEPTH; i++) begin
            first_s  = first_s | c_first_s[i];
            first_d  = first_d | c_first_d[i];
            second_s = second_s | c_second_s[i];
            second_d = second_d | c_second_d[i];
            last_s   = last_s | c_last_s[i];
            last_d   = last_d | c_last_d[i];
            if (bnd[i]) begin
                prune_cnt = prune_cnt | CW'(i + 1);
            end
        end
    end

    // lookup or refused insert result
    always_comb begin
        n_res = '0;
        if (i_req.cmd == CMD_INSERT) begin
            n_res.inserted = 1'b0;
        end else if (r_count == '0) begin
            n_res.error_kind = ERR_EMPTY;
        end else if (target == '0) begin
            n_res.match_count = 2'd1;
            n_res.first_stamp = latest;
            n_res.first_data  = to_word(cell_data[0]);
        end else if (r_count == CW'(1)) begin
            if (latest == target) begin
                n_res.match_count = 2'd1;
                n_res.first_stamp = latest;
                n_res.first_data  = to_word(cell_data[0]);
            end else begin
                n_res.error_kind  = ERR_MISMATCH;
                n_res.bound_stamp = latest;
            end
        end else if (target == latest) begin
            n_res.match_count = 2'd1;
            n_res.first_stamp = latest;
            n_res.first_data  = to_word(cell_data[0]);
        end else if (target == last_s) begin
            n_res.match_count = 2'd1;
            n_res.first_stamp = last_s;
            n_res.first_data  = to_word(last_d);
        end else if (target > latest) begin
            n_res.error_kind  = ERR_FUTURE;
            n_res.bound_stamp = latest;
        end else if (target < last_s) begin
            n_res.error_kind  = ERR_PAST;
            n_res.bound_stamp = last_s;
        end else begin
            n_res.match_count  = 2'd2;
            n_res.first_stamp  = first_s;
            n_res.first_data   = to_word(first_d);
            n_res.second_stamp = second_s;
            n_res.second_data  = to_word(second_d);
        end
    end

    always_comb begin
        ins_res          = '0;
        ins_res.inserted = 1'b1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (r_busy) begin
                r_count <= prune_cnt;
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else if (load) begin
                r_count <= grown;
                r_busy  <= 1'b1;
            end else if (accept) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_result <= ins_res;
        end else if (accept && !load) begin
            r_result <= n_res;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_prune_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy && r_valid && r_result.inserted)
        else $error("prune pass did not finish with an insert result");

    a_no_result_in_prune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_valid)
        else $error("result shown during prune pass");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count beyond depth");

    a_bracket_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_result.match_count != 2'd0) |->
        (r_result.error_kind == ERR_NONE) && !r_result.inserted)
        else $error("lookup match carries an error or insert flag");
`endif

endmodule

// ===== rtl/tssb_cell.sv =====
// ----------------------------------------------------------------------------
// tssb_cell
// One slot of the sorted row: holds an entry, compares it against the
// broadcast stamp and takes the new entry or its left neighbor on insert.
// ----------------------------------------------------------------------------
module tssb_cell
    import tssb_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_occ,
    input  logic [STAMP_W-1:0]   i_key,
    input  logic [DATA_BITS-1:0] i_ins_data,
    input  logic [STAMP_W-1:0]   i_left_stamp,
    input  logic [DATA_BITS-1:0] i_left_data,
    input  t_cell_stat           i_left,
    input  t_cell_stat           i_right,
    input  logic [AGE_W-1:0]     i_max_age,
    input  logic [STAMP_W-1:0]   i_latest,
    output logic [STAMP_W-1:0]   o_stamp,
    output logic [DATA_BITS-1:0] o_data,
    output t_cell_stat           o_stat,
    output logic [STAMP_W-1:0]   o_first_stamp,
    output logic [DATA_BITS-1:0] o_first_data,
    output logic [STAMP_W-1:0]   o_second_stamp,
    output logic [DATA_BITS-1:0] o_second_data,
    output logic [STAMP_W-1:0]   o_last_stamp,
    output logic [DATA_BITS-1:0] o_last_data
);

    logic [STAMP_W-1:0]   r_stamp;
    logic [DATA_BITS-1:0] r_data;
    logic [STAMP_W-1:0]   n_stamp;
    logic [DATA_BITS-1:0] n_data;
    logic                 newer;
    logic                 last;
    logic [STAMP_W:0]     aged;

    assign newer = r_stamp > i_key;
    assign aged  = {1'b0, r_stamp} + {{(STAMP_W + 1 - AGE_W){1'b0}}, i_max_age};
    assign last  = i_occ & ~i_right.occ;

    always_comb begin
        o_stat.occ  = i_occ;
        o_stat.gt   = i_occ & newer;
        o_stat.le   = i_occ & ~newer;
        o_stat.hit  = i_occ & ~newer & ~i_left.le;
        o_stat.keep = i_occ & (aged >= {1'b0, i_latest});
    end

    always_comb begin
        n_stamp = r_stamp;
        n_data  = r_data;
        if (i_load && !o_stat.gt) begin
            if (i_left.gt) begin
                n_stamp = i_key;
                n_data  = i_ins_data;
            end else begin
                n_stamp = i_left_stamp;
                n_data  = i_left_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
        r_data  <= n_data;
    end

    assign o_stamp        = r_stamp;
    assign o_data         = r_data;
    assign o_first_stamp  = o_stat.hit ? r_stamp : '0;
    assign o_first_data   = o_stat.hit ? r_data : '0;
    assign o_second_stamp = i_right.hit ? r_stamp : '0;
    assign o_second_data  = i_right.hit ? r_data : '0;
    assign o_last_stamp   = last ? r_stamp : '0;
    assign o_last_data    = last ? r_data : '0;

endmodule
